/* rtl/svm_pkg.sv */
//------------------------------------------------------------------------------
// svm_pkg
// Shared types, opcodes and sizes of the stack machine execute unit.
//------------------------------------------------------------------------------
package svm_pkg;

  localparam int WORD_BITS  = 32;
  localparam int DATA_DEPTH = 64;
  localparam int CALL_DEPTH = 32;
  localparam int NUM_REGS   = 8;
  localparam int LINE_COUNT = 1024;

  localparam int DA_BITS = $clog2(DATA_DEPTH);
  localparam int DD_BITS = $clog2(DATA_DEPTH + 1);
  localparam int CA_BITS = $clog2(CALL_DEPTH);
  localparam int CD_BITS = $clog2(CALL_DEPTH + 1);
  localparam int RA_BITS = $clog2(NUM_REGS);
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  typedef enum logic [4:0] {
    OP_BEGIN = 5'd0,  OP_END = 5'd1,  OP_PUSH = 5'd2,  OP_POP = 5'd3,
    OP_PUSHR = 5'd4,  OP_POPR = 5'd5, OP_ADD = 5'd6,   OP_SUB = 5'd7,
    OP_MUL = 5'd8,    OP_DIV = 5'd9,  OP_IN = 5'd10,   OP_OUT = 5'd11,
    OP_LABEL = 5'd12, OP_JMP = 5'd13, OP_JEQ = 5'd14,  OP_JNE = 5'd15,
    OP_JGT = 5'd16,   OP_JGE = 5'd17, OP_JLT = 5'd18,  OP_JLE = 5'd19,
    OP_CALL = 5'd20,  OP_RET = 5'd21
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_LABEL = 3'd1, ST_DUNDER = 3'd2, ST_DOVER = 3'd3,
    ST_DIVZERO = 3'd4, ST_CUNDER = 3'd5, ST_COVER = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0, ALU_DIV = 2'd1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

endpackage

/* rtl/svm_alu.sv */
//------------------------------------------------------------------------------
// svm_alu
// Shared iterative unit: shift-add multiply and restoring signed divide,
// one bit per cycle.
//------------------------------------------------------------------------------
module svm_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  svm_pkg::alu_ctl_t            ctl,
  input  logic [svm_pkg::WORD_BITS-1:0] a,
  input  logic [svm_pkg::WORD_BITS-1:0] b,
  output logic                         done,
  output logic [svm_pkg::WORD_BITS-1:0] result
);
  import svm_pkg::*;

  logic                 busy;
  alu_op_t              op;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] opa;
  logic [WORD_BITS-1:0] opb;
  logic                 neg;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_sub;

  // divide: opb holds dividend magnitude shifting out into acc (remainder)
  assign rem_sh  = {acc, opb[WORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, opa};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op  <= ctl.op;
      acc <= '0;
      if (ctl.op == ALU_MUL) begin
        opa <= a;
        opb <= b;
        neg <= 1'b0;
      end else begin
        opa <= a[WORD_BITS-1] ? -a : a;
        opb <= b[WORD_BITS-1] ? -b : b;
        neg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      end
    end else if (busy) begin
      if (op == ALU_MUL) begin
        if (opb[0]) acc <= acc + opa;
        opa <= opa << 1;
        opb <= opb >> 1;
      end else begin
        if (!rem_sub[WORD_BITS]) begin
          acc <= rem_sub[WORD_BITS-1:0];
          opb <= {opb[WORD_BITS-2:0], 1'b1};
        end else begin
          acc <= rem_sh[WORD_BITS-1:0];
          opb <= {opb[WORD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (op == ALU_MUL) result = acc;
    else result = neg ? -opb : opb;
  end

endmodule

/* rtl/stack_vm_instruction_execute_unit.sv */
//------------------------------------------------------------------------------
// stack_vm_instruction_execute_unit
// Executes one stack machine instruction per item.
//------------------------------------------------------------------------------
// One item is taken at a time. Most instructions present their result after
// accept, stack read, execute and result register; mul and div also run
// through a shared one-bit-per-cycle unit after execute. The next item is
// taken the cycle after the result is taken, so a stalled result holds the
// input. The data stack and call stack are memories with registered reads;
// errors leave all state unchanged and report a status with
// next_line = current_line.
module stack_vm_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  action,
  input  logic signed [31:0] immediate,
  input  logic [2:0]  reg_index,
  input  logic signed [10:0] label_line,
  input  logic [9:0]  current_line,
  input  logic signed [31:0] input_value,
  output logic        result_valid,
  input  logic        out_stall,
  output logic [10:0] next_line,
  output logic        halted,
  output logic [2:0]  status,
  output logic        out_valid,
  output logic signed [31:0] out_value
);
  import svm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_EXEC = 5'b00100,
    S_ALU = 5'b01000, S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [4:0]  op;
  logic [31:0] imm, inval;
  logic [RA_BITS-1:0] ridx;
  logic [10:0] lraw;
  logic [9:0]  line;

  logic [WORD_BITS-1:0] dmem [DATA_DEPTH];
  logic [9:0]           cmem [CALL_DEPTH];
  logic [WORD_BITS-1:0] regs [NUM_REGS];
  logic [DD_BITS-1:0]   ddepth;
  logic [CD_BITS-1:0]   cdepth;

  logic [WORD_BITS-1:0] ta, tb;
  logic [9:0]           tc;

  alu_ctl_t             alu_ctl;
  logic                 alu_done;
  logic [WORD_BITS-1:0] alu_res;

  logic                 label_ok;
  logic                 taken;
  logic signed [WORD_BITS-1:0] sa, sb;

  assign in_stall = (state != S_IDLE);
  assign label_ok = !lraw[10];
  assign sa = ta;
  assign sb = tb;

  always_comb begin
    case (op)
      OP_JEQ:  taken = (sa == sb);
      OP_JNE:  taken = (sa != sb);
      OP_JGT:  taken = (sa > sb);
      OP_JGE:  taken = (sa >= sb);
      OP_JLT:  taken = (sa < sb);
      default: taken = (sa <= sb);
    endcase
  end

  svm_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (ta),
    .b      (tb),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    alu_ctl.start = (state == S_EXEC) && ddepth >= DD_BITS'(2) &&
                    (op == OP_MUL || (op == OP_DIV && ta != '0));
    alu_ctl.op    = (op == OP_MUL) ? ALU_MUL : ALU_DIV;
  end

  // registered stack reads
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      ta <= dmem[DA_BITS'(ddepth - 1'b1)];
      tb <= dmem[DA_BITS'(ddepth - DD_BITS'(2))];
      tc <= cmem[CA_BITS'(cdepth - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op    <= action;
      imm   <= immediate;
      inval <= input_value;
      ridx  <= RA_BITS'(reg_index);
      lraw  <= label_line;
      line  <= current_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ddepth       <= '0;
      cdepth       <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          next_line <= {1'b0, line} + 11'd1;
          halted    <= 1'b0;
          status    <= ST_OK;
          out_valid <= 1'b0;
          out_value <= '0;
          state     <= S_DONE;
          case (op)
            OP_END: begin
              halted    <= 1'b1;
              next_line <= '0;
            end
            OP_PUSH, OP_PUSHR, OP_IN: begin
              if (ddepth >= DD_BITS'(DATA_DEPTH)) begin
                status <= ST_DOVER;
              end else begin
                dmem[DA_BITS'(ddepth)] <= (op == OP_PUSH) ? imm :
                                          (op == OP_PUSHR) ? regs[ridx] : inval;
                ddepth <= ddepth + 1'b1;
              end
            end
            OP_POP, OP_POPR, OP_OUT: begin
              if (ddepth == '0) begin
                status <= ST_DUNDER;
              end else begin
                ddepth <= ddepth - 1'b1;
                if (op == OP_POPR) regs[ridx] <= ta;
                if (op == OP_OUT) begin
                  out_valid <= 1'b1;
                  out_value <= ta;
                end
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (ddepth < DD_BITS'(2)) begin
                status <= ST_DUNDER;
              end else if (op == OP_ADD || op == OP_SUB) begin
                dmem[DA_BITS'(ddepth - DD_BITS'(2))] <= (op == OP_ADD) ? tb + ta : tb - ta;
                ddepth <= ddepth - 1'b1;
              end else if (op == OP_DIV && ta == '0) begin
                status <= ST_DIVZERO;
              end else begin
                state <= S_ALU;
              end
            end
            OP_JEQ, OP_JNE, OP_JGT, OP_JGE, OP_JLT, OP_JLE: begin
              if (ddepth < DD_BITS'(2)) status <= ST_DUNDER;
              else if (taken) begin
                if (label_ok) next_line <= lraw;
                else status <= ST_LABEL;
              end
            end
            OP_JMP: begin
              if (label_ok) next_line <= lraw;
              else status <= ST_LABEL;
            end
            OP_CALL: begin
              if (!label_ok) status <= ST_LABEL;
              else if (cdepth >= CD_BITS'(CALL_DEPTH)) status <= ST_COVER;
              else begin
                cmem[CA_BITS'(cdepth)] <= line;
                cdepth    <= cdepth + 1'b1;
                next_line <= lraw;
              end
            end
            OP_RET: begin
              if (cdepth == '0) status <= ST_CUNDER;
              else begin
                cdepth    <= cdepth - 1'b1;
                next_line <= {1'b0, tc} + 11'd1;
              end
            end
            default: ;
          endcase
        end
        S_ALU: begin
          if (alu_done) begin
            dmem[DA_BITS'(ddepth - DD_BITS'(2))] <= alu_res;
            ddepth <= ddepth - 1'b1;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid) begin
            result_valid <= 1'b1;
            // error results report the current line
            if (status != ST_OK) next_line <= {1'b0, line};
          end else if (!out_stall) begin
            result_valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/stack_vm_instruction_execute_unit_tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// stack_vm_instruction_execute_unit_tb
// Runs directed and random instruction streams through the execute unit with
// random idling on both sides. Each result is checked field by field against
// a built-in model of the stacks and registers.
//------------------------------------------------------------------------------
module stack_vm_instruction_execute_unit_tb;
  import svm_pkg::*;

  typedef struct {
    logic [4:0]         action;
    logic signed [31:0] immediate;
    logic [2:0]         reg_index;
    logic signed [10:0] label_line;
    logic [9:0]         current_line;
    logic signed [31:0] input_value;
  } instr_t;

  typedef struct {
    logic [10:0]        next_line;
    logic               halted;
    logic [2:0]         status;
    logic               out_valid;
    logic signed [31:0] out_value;
  } exec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] action = '0;
  logic signed [31:0] immediate = '0;
  logic [2:0] reg_index = '0;
  logic signed [10:0] label_line = '0;
  logic [9:0] current_line = '0;
  logic signed [31:0] input_value = '0;
  logic result_valid;
  logic out_stall = 1'b0;
  logic [10:0] next_line;
  logic halted;
  logic [2:0] status;
  logic out_valid;
  logic signed [31:0] out_value;

  stack_vm_instruction_execute_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .immediate(immediate), .reg_index(reg_index),
    .label_line(label_line), .current_line(current_line),
    .input_value(input_value), .result_valid(result_valid),
    .out_stall(out_stall), .next_line(next_line), .halted(halted),
    .status(status), .out_valid(out_valid), .out_value(out_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  instr_t    pending_instrs[$];
  exec_res_t expected_results[$];
  int        errors = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_off = 1'b0;

  // shadow machine state
  logic [31:0] m_data[DATA_DEPTH];
  int          m_ddepth = 0;
  logic [9:0]  m_call[CALL_DEPTH];
  int          m_cdepth = 0;
  logic [31:0] m_regs[NUM_REGS];

  function automatic bit branch_taken(logic [4:0] op, logic signed [31:0] a,
                                      logic signed [31:0] b);
    case (op)
      OP_JEQ:  return a == b;
      OP_JNE:  return a != b;
      OP_JGT:  return a > b;
      OP_JGE:  return a >= b;
      OP_JLT:  return a < b;
      default: return a <= b;
    endcase
  endfunction

  function automatic exec_res_t execute_instr(instr_t it);
    exec_res_t r;
    logic signed [31:0] a, b, v;
    logic [31:0] q;
    bit lok;
    r = '{next_line: 11'(it.current_line) + 11'd1, halted: 1'b0,
          status: ST_OK, out_valid: 1'b0, out_value: '0};
    lok = it.label_line >= 0 && it.label_line < LINE_COUNT;
    case (it.action)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (m_ddepth < 2) r.status = ST_DUNDER;
        else begin
          a = m_data[m_ddepth-1];
          b = m_data[m_ddepth-2];
          case (it.action)
            OP_ADD: q = a + b;
            OP_SUB: q = b - a;
            OP_MUL: q = a * b;
            default: begin
              if (a == 0) r.status = ST_DIVZERO;
              else if (b == 32'sh80000000 && a == -1) q = b;
              else q = b / a;
            end
          endcase
          if (r.status == ST_OK) begin
            m_ddepth--;
            m_data[m_ddepth-1] = q;
          end
        end
      end
      OP_JEQ, OP_JNE, OP_JGT, OP_JGE, OP_JLT, OP_JLE: begin
        if (m_ddepth < 2) r.status = ST_DUNDER;
        else if (branch_taken(it.action, m_data[m_ddepth-1], m_data[m_ddepth-2])) begin
          if (lok) r.next_line = 11'(it.label_line);
          else r.status = ST_LABEL;
        end
      end
      OP_END: begin
        r.halted = 1'b1;
        r.next_line = '0;
      end
      OP_PUSH, OP_PUSHR, OP_IN: begin
        if (m_ddepth >= DATA_DEPTH) r.status = ST_DOVER;
        else begin
          v = (it.action == OP_PUSH) ? it.immediate :
              (it.action == OP_PUSHR) ? m_regs[it.reg_index % NUM_REGS] : it.input_value;
          m_data[m_ddepth++] = v;
        end
      end
      OP_POP, OP_POPR, OP_OUT: begin
        if (m_ddepth == 0) r.status = ST_DUNDER;
        else begin
          v = m_data[--m_ddepth];
          if (it.action == OP_POPR) m_regs[it.reg_index % NUM_REGS] = v;
          if (it.action == OP_OUT) begin
            r.out_valid = 1'b1;
            r.out_value = v;
          end
        end
      end
      OP_JMP: begin
        if (lok) r.next_line = 11'(it.label_line);
        else r.status = ST_LABEL;
      end
      OP_CALL: begin
        if (!lok) r.status = ST_LABEL;
        else if (m_cdepth >= CALL_DEPTH) r.status = ST_COVER;
        else begin
          m_call[m_cdepth++] = it.current_line;
          r.next_line = 11'(it.label_line);
        end
      end
      OP_RET: begin
        if (m_cdepth == 0) r.status = ST_CUNDER;
        else r.next_line = 11'(m_call[--m_cdepth]) + 11'd1;
      end
      default: ;
    endcase
    if (r.status != ST_OK) begin
      r.next_line = 11'(it.current_line);
      r.halted = 1'b0;
      r.out_valid = 1'b0;
      r.out_value = '0;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr(logic [4:0] op);
    instr_t it;
    it.action = op;
    it.immediate = rand_word();
    it.reg_index = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: it.label_line = -1;
      1: it.label_line = 11'($urandom_range(1024, 2047));
      2: it.label_line = 11'd1023;
      default: it.label_line = 11'($urandom_range(0, 1023));
    endcase
    it.current_line = 10'($urandom_range(0, 1023));
    it.input_value = rand_word();
    return it;
  endfunction

  task automatic add_instr(logic [4:0] op);
    pending_instrs.push_back(rand_instr(op));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_instrs.size() > 0 && !hold_off &&
          (no_idle || $urandom_range(0, 99) >= 32)) begin
        instr_t it;
        it = pending_instrs.pop_front();
        expected_results.push_back(execute_instr(it));
        action <= it.action;
        immediate <= it.immediate;
        reg_index <= it.reg_index;
        label_line <= it.label_line;
        current_line <= it.current_line;
        input_value <= it.input_value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (result_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result next_line=%0d", $time, next_line);
          errors++;
        end else begin
          exec_res_t e;
          e = expected_results.pop_front();
          if (next_line !== e.next_line) begin
            $display("%0t: next_line exp %0d act %0d", $time, e.next_line, next_line);
            errors++;
          end
          if (halted !== e.halted) begin
            $display("%0t: halted exp %0d act %0d", $time, e.halted, halted);
            errors++;
          end
          if (status !== e.status) begin
            $display("%0t: status exp %0d act %0d", $time, e.status, status);
            errors++;
          end
          if (out_valid !== e.out_valid) begin
            $display("%0t: out_valid exp %0d act %0d", $time, e.out_valid, out_valid);
            errors++;
          end
          if (out_value !== e.out_value) begin
            $display("%0t: out_value exp %0d act %0d", $time, e.out_value, out_value);
            errors++;
          end
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("stack_vm_instruction_execute_unit_tb failed");
      $finish;
    end
  end

  initial begin
    logic [4:0] op;
    for (int i = 0; i < NUM_REGS; i++) m_regs[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: underflows on empty machine, then extremes
    add_instr(OP_POP);
    add_instr(OP_ADD);
    add_instr(OP_RET);
    add_instr(OP_JEQ);
    add_instr(OP_BEGIN);
    add_instr(OP_END);
    add_instr(OP_LABEL);
    add_instr(5'd31);
    pending_instrs.push_back('{OP_PUSH, 32'sh80000000, 3'd0, 11'sd5, 10'd0, 32'sd0});
    pending_instrs.push_back('{OP_PUSH, -32'sd1, 3'd7, 11'sd5, 10'd1023, 32'sd0});
    pending_instrs.push_back('{OP_DIV, 32'sd0, 3'd0, 11'sd0, 10'd2, 32'sd0});
    pending_instrs.push_back('{OP_IN, 32'sd0, 3'd0, 11'sd0, 10'd3, 32'sh7fffffff});
    pending_instrs.push_back('{OP_PUSH, 32'sd0, 3'd0, 11'sd0, 10'd4, 32'sd0});
    pending_instrs.push_back('{OP_DIV, 32'sd0, 3'd0, 11'sd0, 10'd5, 32'sd0});
    pending_instrs.push_back('{OP_JMP, 32'sd0, 3'd0, -11'sd1, 10'd6, 32'sd0});
    pending_instrs.push_back('{OP_JMP, 32'sd0, 3'd0, 11'sd1023, 10'd7, 32'sd0});
    pending_instrs.push_back('{OP_JNE, 32'sd0, 3'd0, -11'sd1, 10'd8, 32'sd0});
    pending_instrs.push_back('{OP_CALL, 32'sd0, 3'd0, 11'sd1024, 10'd9, 32'sd0});
    pending_instrs.push_back('{OP_CALL, 32'sd0, 3'd0, 11'sd100, 10'd1023, 32'sd0});
    pending_instrs.push_back('{OP_RET, 32'sd0, 3'd0, 11'sd0, 10'd100, 32'sd0});
    add_instr(OP_POPR);
    add_instr(OP_PUSHR);
    add_instr(OP_OUT);
    add_instr(OP_MUL);
    add_instr(OP_SUB);

    // random: mostly valid ops, with runs that fill both stacks and drain the call stack
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        wait (pending_instrs.size() == 0);
        hold_off = 1'b1;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge clk);
        hold_off = 1'b0;
        no_idle = 1'b1;
      end
      if (n == 450) no_idle = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2: op = ($urandom_range(0, 3) == 0) ? OP_PUSHR :
                      ($urandom_range(0, 1) ? OP_PUSH : OP_IN);
        3: op = 5'($urandom_range(OP_ADD, OP_DIV));
        4: op = 5'($urandom_range(OP_JEQ, OP_JLE));
        5: op = $urandom_range(0, 1) ? OP_CALL : OP_RET;
        6: op = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(22, 31)) :
                5'($urandom_range(OP_BEGIN, OP_END) |
                   5'($urandom_range(0, 1) ? OP_LABEL : 0));
        7: op = OP_JMP;
        default: op = 5'($urandom_range(OP_POP, OP_POPR) |
                         5'($urandom_range(0, 1) << 3));
      endcase
      if (op == OP_JMP && $urandom_range(0, 1) == 0) op = OP_OUT;
      // bursts toward overflow and underflow
      if (n % 300 == 100)
        for (int k = 0; k < 70; k++) add_instr(OP_PUSH);
      if (n % 300 == 150)
        for (int k = 0; k < 36; k++) add_instr(OP_CALL);
      if (n % 300 == 170)
        for (int k = 0; k < 36; k++) add_instr(OP_RET);
      add_instr(op);
    end
    wait (pending_instrs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("stack_vm_instruction_execute_unit_tb passed");
    end else begin
      $display("stack_vm_instruction_execute_unit_tb failed");
    end
    $finish;
  end

endmodule

/* stack_vm_instruction_execute_unit.f */
rtl/svm_pkg.sv
rtl/svm_alu.sv
rtl/stack_vm_instruction_execute_unit.sv
tb/sv/stack_vm_instruction_execute_unit_tb.sv
